// File: sv/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, register codes, payload types and divider step helpers for
// the ray/triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int BARY_FRAC_BITS  = 16;

  localparam int CW   = 32;
  localparam int EW   = CW + 1;
  localparam int XW   = 2 * EW + 1;
  localparam int DW   = 102;
  localparam int MW   = DW - 1;
  localparam int OPW  = 68;
  localparam int LW   = OPW / 2;
  localparam int PW   = 2 * OPW;
  localparam int NW   = PW;
  localparam int WOW  = 136;
  localparam int WLW  = 34;
  localparam int WLN  = WOW / WLW;
  localparam int WPW  = 2 * WOW;
  localparam int QW   = 32;
  localparam int UVW  = 17;
  localparam int DEPW = 48;
  localparam int PEW  = 31;
  localparam int PDW  = 64;
  localparam int BSH  = 3;
  localparam int AW   = BSH + 3;

  localparam int LN_U  = 0;
  localparam int LN_V  = 1;
  localparam int LN_T  = 2;
  localparam int NLANE = 3;

  localparam logic [CW-1:0] DIR_X_RST = CW'(64'(1) << COORD_FRAC_BITS);
  localparam logic [QW-1:0] T_POS_LIM = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] T_NEG_LIM = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [AW-BSH-1:0] {
    REG_ORG_X,
    REG_ORG_Y,
    REG_ORG_Z,
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z,
    REG_DET_EPS,
    REG_PLANE_EPS
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
  } tri_t;

  typedef struct packed {
    logic                 hit;
    logic                 on_plane;
    logic signed [QW-1:0] dist_t;
    logic [UVW-1:0]       bary_u;
    logic [UVW-1:0]       bary_v;
  } res_t;

  typedef struct packed {
    logic [MW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic par;
    logic miss;
    logic tneg;
    logic sat;
    logic on_plane;
  } flags_t;

  typedef struct packed {
    logic [MW-1:0]          det;
    lane_t [NLANE-1:0]      lane;
    flags_t                 flg;
  } dv_t;

  function automatic lane_t lane_init(logic [MW-1:0] x, int f);
    logic [MW+QW-1:0] n;
    lane_t r;
    n = (MW+QW)'(x) << f;
    r.rem = n[MW+QW-1:QW];
    r.low = n[QW-1:0];
    r.quo = '0;
    return r;
  endfunction

  function automatic lane_t div_step(lane_t l, logic [MW-1:0] det);
    logic [MW:0] t;
    lane_t r;
    t = {l.rem, l.low[QW-1]};
    r.low = {l.low[QW-2:0], 1'b0};
    if (t >= {1'b0, det}) begin
      r.rem = MW'(t - {1'b0, det});
      r.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      r.rem = t[MW-1:0];
      r.quo = {l.quo[QW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: sv/ray_triangle_intersector_unit.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersector_unit
// Moller-Trumbore ray/triangle test in exact fixed point against a ray held
// in configuration registers: one triangle per cycle when not stalled.
//
// The ray origin, direction and the two tolerances are written over the APB
// port; the user must write them only while the pipeline is empty, as the
// block does not enforce this. pready is always high. Each transaction on
// the tri channel carries the three vertices of one triangle, and each
// produces exactly one transaction on the res channel with hit, on_plane,
// dist_t, bary_u and bary_v, in input order. Throughput is one triangle
// per cycle unless res_ready holds the pipeline. A triangle goes through
// cross and dot products in split multipliers, sign and bound tests, one
// divider step per quotient bit for the 32-bit restoring divider lanes.
// The plane test runs beside the divider in a three-stage wide multiplier.
// When res_ready is low while a result waits, the whole pipeline holds and
// tri_ready drops; nothing is lost or repeated. Reset clears all valid bits
// and returns the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module ray_triangle_intersector_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    tri_valid,
  output logic                    tri_ready,
  input  rti_pkg::tri_t           tri_data,
  output logic                    res_valid,
  input  logic                    res_ready,
  output rti_pkg::res_t           res_data,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [rti_pkg::AW-1:0]  paddr,
  input  logic [rti_pkg::PDW-1:0] pwdata,
  output logic [rti_pkg::PDW-1:0] prdata,
  output logic                    pready
);
  import rti_pkg::*;

  localparam int M_LAT   = 2;
  localparam int WM_LAT  = 3;
  localparam int ST_E    = 1;
  localparam int ST_X    = ST_E + M_LAT + 1;
  localparam int ST_D    = ST_X + M_LAT + 1;
  localparam int ST_N    = ST_D + 1;
  localparam int ST_B    = ST_N + 1;
  localparam int ST_V0   = ST_B + 1;
  localparam int OP_STEP = ST_N + WM_LAT - ST_V0 + 1;
  localparam int NST     = ST_V0 + QW + 1;

  localparam int D_DET = 0;
  localparam int D_UN  = 1;
  localparam int D_VN  = 2;
  localparam int D_TN  = 3;
  localparam int D_SN  = 4;
  localparam int D_NN  = 5;

  logic                 en;
  logic [NST:1]         vld;
  logic                 wr;
  reg_idx_t             ridx;
  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];
  logic [DEPW-1:0]      det_eps;
  logic [PEW-1:0]       pe;
  logic [2*PEW-1:0]     pe_sq;

  logic signed [CW-1:0]  va [3];
  logic signed [CW-1:0]  vb [3];
  logic signed [CW-1:0]  vc [3];
  logic signed [EW-1:0]  ev [ST_E:ST_X][3][3];
  logic signed [OPW-1:0] xa [3][3];
  logic signed [OPW-1:0] ya [3][3];
  logic signed [PW-1:0]  pa [3][3][2];
  logic signed [XW-1:0]  crs [3][3];
  logic signed [OPW-1:0] xb [6][3];
  logic signed [OPW-1:0] yb [6][3];
  logic signed [PW-1:0]  pb [6][3];
  logic signed [DW-1:0]  dot [5];
  logic [NW-1:0]         nn;

  logic                 dneg;
  logic [MW-1:0]        det_mag;
  logic [MW-1:0]        det8;
  logic [MW-1:0]        sna8;
  logic signed [DW-1:0] un8;
  logic signed [DW-1:0] vn8;
  logic signed [DW-1:0] tn8;
  logic [NW-1:0]        nn8;
  logic                 par8;

  logic                 miss_next;
  logic [MW-1:0]        det9;
  logic [MW-1:0]        un9;
  logic [MW-1:0]        vn9;
  logic [MW-1:0]        ta9;
  logic                 tneg9;
  logic                 par9;
  logic                 miss9;

  logic [WOW-1:0] wa [2];
  logic [WOW-1:0] wb [2];
  logic [WPW-1:0] wp [2];

  dv_t            dv [0:QW];
  dv_t            dv_next [0:QW];
  flags_t         fl;
  logic [QW-1:0]  qt;
  logic [QW-1:0]  lim;
  logic [QW-1:0]  tq;
  logic           hit;
  res_t           res_next;

  assign en        = !res_valid || res_ready;
  assign tri_ready = en;
  assign res_valid = vld[NST];
  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite && pready;
  assign ridx      = reg_idx_t'(paddr[AW-1:BSH]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
      end
      dir[0]  <= DIR_X_RST;
      dir[1]  <= '0;
      dir[2]  <= '0;
      det_eps <= DEPW'(1);
      pe      <= PEW'(1);
    end else if (wr) begin
      unique case (ridx)
        REG_ORG_X:     org[0]  <= pwdata[CW-1:0];
        REG_ORG_Y:     org[1]  <= pwdata[CW-1:0];
        REG_ORG_Z:     org[2]  <= pwdata[CW-1:0];
        REG_DIR_X:     dir[0]  <= pwdata[CW-1:0];
        REG_DIR_Y:     dir[1]  <= pwdata[CW-1:0];
        REG_DIR_Z:     dir[2]  <= pwdata[CW-1:0];
        REG_DET_EPS:   det_eps <= pwdata[DEPW-1:0];
        REG_PLANE_EPS: pe      <= pwdata[PEW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ORG_X:     prdata = {{(PDW-CW){1'b0}}, org[0]};
      REG_ORG_Y:     prdata = {{(PDW-CW){1'b0}}, org[1]};
      REG_ORG_Z:     prdata = {{(PDW-CW){1'b0}}, org[2]};
      REG_DIR_X:     prdata = {{(PDW-CW){1'b0}}, dir[0]};
      REG_DIR_Y:     prdata = {{(PDW-CW){1'b0}}, dir[1]};
      REG_DIR_Z:     prdata = {{(PDW-CW){1'b0}}, dir[2]};
      REG_DET_EPS:   prdata = {{(PDW-DEPW){1'b0}}, det_eps};
      REG_PLANE_EPS: prdata = {{(PDW-PEW){1'b0}}, pe};
    endcase
  end

  always_ff @(posedge clk) begin
    pe_sq <= pe * pe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:1], tri_valid};
    end
  end

  always_comb begin
    va[0] = tri_data.a_x;
    va[1] = tri_data.a_y;
    va[2] = tri_data.a_z;
    vb[0] = tri_data.b_x;
    vb[1] = tri_data.b_y;
    vb[2] = tri_data.b_z;
    vc[0] = tri_data.c_x;
    vc[1] = tri_data.c_y;
    vc[2] = tri_data.c_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ev[ST_E][0][i] <= EW'(vb[i]) - EW'(va[i]);
        ev[ST_E][1][i] <= EW'(vc[i]) - EW'(va[i]);
        ev[ST_E][2][i] <= EW'(org[i]) - EW'(va[i]);
      end
      for (int st = ST_E + 1; st <= ST_X; st++) begin
        ev[st] <= ev[st-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xa[0][i] = OPW'(dir[i]);
      ya[0][i] = OPW'(ev[ST_E][1][i]);
      xa[1][i] = OPW'(ev[ST_E][0][i]);
      ya[1][i] = OPW'(ev[ST_E][1][i]);
      xa[2][i] = OPW'(ev[ST_E][2][i]);
      ya[2][i] = OPW'(ev[ST_E][0][i]);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_cross
    for (genvar i = 0; i < 3; i++) begin : g_comp
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      rti_mul u_mul_jk (.clk(clk), .en(en), .a(xa[g][J]), .b(ya[g][K]), .p(pa[g][i][0]));
      rti_mul u_mul_kj (.clk(clk), .en(en), .a(xa[g][K]), .b(ya[g][J]), .p(pa[g][i][1]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 3; g++) begin
        for (int i = 0; i < 3; i++) begin
          crs[g][i] <= XW'(pa[g][i][0]) - XW'(pa[g][i][1]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xb[D_DET][i] = OPW'(ev[ST_X][0][i]);
      yb[D_DET][i] = OPW'(crs[0][i]);
      xb[D_UN][i]  = OPW'(ev[ST_X][2][i]);
      yb[D_UN][i]  = OPW'(crs[0][i]);
      xb[D_VN][i]  = OPW'(dir[i]);
      yb[D_VN][i]  = OPW'(crs[2][i]);
      xb[D_TN][i]  = OPW'(ev[ST_X][1][i]);
      yb[D_TN][i]  = OPW'(crs[2][i]);
      xb[D_SN][i]  = OPW'(ev[ST_X][2][i]);
      yb[D_SN][i]  = OPW'(crs[1][i]);
      xb[D_NN][i]  = OPW'(crs[1][i]);
      yb[D_NN][i]  = OPW'(crs[1][i]);
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_comp
      rti_mul u_mul (.clk(clk), .en(en), .a(xb[g][i]), .b(yb[g][i]), .p(pb[g][i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 5; g++) begin
        dot[g] <= DW'(pb[g][0]) + DW'(pb[g][1]) + DW'(pb[g][2]);
      end
      nn <= NW'(pb[D_NN][0]) + NW'(pb[D_NN][1]) + NW'(pb[D_NN][2]);
    end
  end

  assign dneg    = dot[D_DET][DW-1];
  assign det_mag = MW'(dneg ? -dot[D_DET] : dot[D_DET]);

  always_ff @(posedge clk) begin
    if (en) begin
      det8 <= det_mag;
      un8  <= dneg ? -dot[D_UN] : dot[D_UN];
      vn8  <= dneg ? -dot[D_VN] : dot[D_VN];
      tn8  <= dneg ? -dot[D_TN] : dot[D_TN];
      sna8 <= MW'(dot[D_SN][DW-1] ? -dot[D_SN] : dot[D_SN]);
      nn8  <= nn;
      par8 <= (det_mag == '0) || (det_mag < MW'(det_eps));
    end
  end

  assign miss_next = un8[DW-1] || vn8[DW-1] || ($signed({1'b0, det8}) < un8)
                     || ($signed({2'b0, det8}) < ((DW+1)'(un8) + (DW+1)'(vn8)));

  always_ff @(posedge clk) begin
    if (en) begin
      det9  <= det8;
      un9   <= MW'(un8);
      vn9   <= MW'(vn8);
      ta9   <= MW'(tn8[DW-1] ? -tn8 : tn8);
      tneg9 <= tn8[DW-1];
      par9  <= par8;
      miss9 <= miss_next;
    end
  end

  assign wa[0] = WOW'(sna8);
  assign wb[0] = WOW'(sna8);
  assign wa[1] = WOW'(pe_sq);
  assign wb[1] = WOW'(nn8);

  for (genvar m = 0; m < 2; m++) begin : g_plane
    rti_wide_mul u_wmul (.clk(clk), .en(en), .a(wa[m]), .b(wb[m]), .p(wp[m]));
  end

  always_comb begin
    dv_next[0].det           = det9;
    dv_next[0].lane[LN_U]    = lane_init(un9, BARY_FRAC_BITS);
    dv_next[0].lane[LN_V]    = lane_init(vn9, BARY_FRAC_BITS);
    dv_next[0].lane[LN_T]    = lane_init(ta9, COORD_FRAC_BITS);
    dv_next[0].flg.par       = par9;
    dv_next[0].flg.miss      = miss9;
    dv_next[0].flg.tneg      = tneg9;
    dv_next[0].flg.sat       = dv_next[0].lane[LN_T].rem >= det9;
    dv_next[0].flg.on_plane  = 1'b0;
    for (int k = 1; k <= QW; k++) begin
      dv_next[k].det = dv[k-1].det;
      for (int l = 0; l < NLANE; l++) begin
        dv_next[k].lane[l] = div_step(dv[k-1].lane[l], dv[k-1].det);
      end
      dv_next[k].flg = dv[k-1].flg;
      if (k == OP_STEP) begin
        dv_next[k].flg.on_plane = !(wp[1] < wp[0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= QW; k++) begin
        dv[k] <= dv_next[k];
      end
    end
  end

  always_comb begin
    fl  = dv[QW].flg;
    qt  = dv[QW].lane[LN_T].quo;
    lim = fl.tneg ? T_NEG_LIM : T_POS_LIM;
    tq  = (fl.sat || (qt > lim)) ? lim : qt;
    hit = !fl.par && !fl.miss;
    res_next.hit      = hit;
    res_next.on_plane = fl.par && fl.on_plane;
    res_next.dist_t   = hit ? (fl.tneg ? -tq : tq) : '0;
    res_next.bary_u   = hit ? dv[QW].lane[LN_U].quo[UVW-1:0] : '0;
    res_next.bary_v   = hit ? dv[QW].lane[LN_V].quo[UVW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data <= res_next;
    end
  end

endmodule

// File: sv/rti_mul.sv
// ----------------------------------------------------------------------------
// rti_mul
// Two-stage signed multiplier: four registered partial products, then sum.
// ----------------------------------------------------------------------------
module rti_mul (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [rti_pkg::OPW-1:0] a,
  input  logic signed [rti_pkg::OPW-1:0] b,
  output logic signed [rti_pkg::PW-1:0]  p
);
  import rti_pkg::*;

  logic signed [LW-1:0]   ah;
  logic signed [LW-1:0]   bh;
  logic [LW-1:0]          al;
  logic [LW-1:0]          bl;
  logic signed [2*LW-1:0] pp_hh;
  logic signed [2*LW:0]   pp_hl;
  logic signed [2*LW:0]   pp_lh;
  logic [2*LW-1:0]        pp_ll;

  assign ah = a[OPW-1:LW];
  assign al = a[LW-1:0];
  assign bh = b[OPW-1:LW];
  assign bl = b[LW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= ah * bh;
      pp_hl <= ah * $signed({1'b0, bl});
      pp_lh <= $signed({1'b0, al}) * bh;
      pp_ll <= al * bl;
      p     <= (PW'(pp_hh) << (2 * LW)) + (PW'(pp_hl) << LW) + (PW'(pp_lh) << LW)
               + PW'(pp_ll);
    end
  end

endmodule

// File: sv/rti_wide_mul.sv
// ----------------------------------------------------------------------------
// rti_wide_mul
// Three-stage wide unsigned multiplier: limb products, row sums, total.
// ----------------------------------------------------------------------------
module rti_wide_mul (
  input  logic                    clk,
  input  logic                    en,
  input  logic [rti_pkg::WOW-1:0] a,
  input  logic [rti_pkg::WOW-1:0] b,
  output logic [rti_pkg::WPW-1:0] p
);
  import rti_pkg::*;

  logic [2*WLW-1:0] pp [WLN][WLN];
  logic [WPW-1:0]   row [WLN];
  logic [WPW-1:0]   row_next [WLN];
  logic [WPW-1:0]   p_next;

  always_comb begin
    for (int i = 0; i < WLN; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < WLN; j++) begin
        row_next[i] = row_next[i] + (WPW'(pp[i][j]) << (WLW * (i + j)));
      end
    end
    p_next = '0;
    for (int i = 0; i < WLN; i++) begin
      p_next = p_next + row[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < WLN; i++) begin
        for (int j = 0; j < WLN; j++) begin
          pp[i][j] <= a[i*WLW +: WLW] * b[j*WLW +: WLW];
        end
        row[i] <= row_next[i];
      end
      p <= p_next;
    end
  end

endmodule
